// File: design/frame_overlap_smoother_top_assert.svh
// Assertion macros for the frame overlap smoother checker.
`ifndef FRAME_OVERLAP_SMOOTHER_TOP_ASSERT_SVH
`define FRAME_OVERLAP_SMOOTHER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FOS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FOS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/fos_pkg.sv
// Shared types, constants and step schedule of the frame overlap smoother.
`timescale 1ns / 1ps
package fos_pkg;

	localparam int FRAME_LEN       = 10;
	localparam int HALF            = FRAME_LEN / 2;
	localparam int AXES            = 3;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int IDX_W           = $clog2(FRAME_LEN);
	localparam int STEP_W          = $clog2(2 * FRAME_LEN);
	localparam int CFG_ADDR_W      = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_FILTER_EN = '0;

	typedef enum logic [1:0] {
		PLAN_RAW,
		PLAN_COPY,
		PLAN_MERGE
	} plan_t;

	typedef enum logic [1:0] {
		SRC_BUF,
		SRC_PREV,
		SRC_SCR
	} src_t;

	typedef enum logic [1:0] {
		DST_NONE,
		DST_PREV,
		DST_SCR
	} dst_t;

	typedef struct packed {
		src_t             src;
		dst_t             dst;
		logic             emit;
		logic             last;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic [IDX_W-1:0] idx;
		logic [3:0]       divisor;
	} step_t;

	typedef struct packed {
		logic       start;
		logic [3:0] divisor;
	} div_ctrl_t;

	// window, source and target of one step of a frame-end plan
	function automatic step_t fos_step(plan_t plan, logic [STEP_W-1:0] step);
		int    s;
		int    k;
		int    h;
		step_t r;
		s = int'(step);
		k = s;
		r.src  = SRC_BUF;
		r.dst  = DST_NONE;
		r.emit = 1'b0;
		r.last = (s == FRAME_LEN - 1);
		r.idx  = IDX_W'(s);
		case (plan)
			PLAN_RAW: begin
				r.emit = 1'b1;
			end
			PLAN_COPY: begin
				r.dst = DST_PREV;
			end
			PLAN_MERGE: begin
				r.last = 1'b0;
				if (s < HALF) begin
					k     = HALF - 1 + s;
					r.src = SRC_PREV;
					r.dst = DST_SCR;
				end else if (s < FRAME_LEN) begin
					k     = 1 + s - HALF;
					r.src = SRC_BUF;
					r.dst = DST_SCR;
				end else begin
					k      = s - FRAME_LEN;
					r.src  = SRC_SCR;
					r.dst  = DST_PREV;
					r.emit = 1'b1;
					r.idx  = IDX_W'(k);
					r.last = (k == FRAME_LEN - 1);
				end
			end
			default: begin
				r.emit = 1'b1;
			end
		endcase
		if (plan == PLAN_MERGE) begin
			h = (k < FRAME_LEN - 1 - k) ? k : FRAME_LEN - 1 - k;
		end else begin
			h = 0;
		end
		r.lo      = IDX_W'(k - h);
		r.hi      = IDX_W'(k + h);
		r.divisor = 4'(2 * h + 1);
		return r;
	endfunction

	// one base-16 quotient digit: t < 16*d, d odd and at most 9
	function automatic logic [3:0] fos_digit(logic [7:0] t, logic [3:0] d);
		logic [15:0] p;
		logic [3:0]  q;
		p = '0;
		case (d)
			4'd3: begin
				p = 16'(t) * 16'd171;
				q = p[12:9];
			end
			4'd5: begin
				p = 16'(t) * 16'd205;
				q = p[13:10];
			end
			4'd7: begin
				p = 16'(t) * 16'd147;
				q = p[13:10];
			end
			4'd9: begin
				p = 16'(t) * 16'd57;
				q = p[12:9];
			end
			default: begin
				q = t[3:0];
			end
		endcase
		return q;
	endfunction

endpackage

// File: design/fos_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module fos_ram #(
	parameter int WIDTH = 3 * fos_pkg::SAMPLE_BITS_DEF,
	parameter int DEPTH = fos_pkg::FRAME_LEN
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/fos_cdiv.sv
// Signed divide by a small odd constant, one base-16 digit per cycle, truncating.
`timescale 1ns / 1ps
module fos_cdiv #(
	parameter int SAMPLE_BITS = fos_pkg::SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fos_pkg::div_ctrl_t        ctrl,
	input  logic signed [SAMPLE_BITS+3:0] sum,
	output logic                      done,
	output logic [SAMPLE_BITS-1:0]    quotient
);
	import fos_pkg::*;

	localparam int SW    = SAMPLE_BITS + 4;
	localparam int ND    = (SW + 3) / 4;
	localparam int DW    = ND * 4;
	localparam int CNT_W = $clog2(ND);

	logic [SW-1:0]    abs_sum;
	logic [DW-1:0]    mag_q;
	logic [DW-1:0]    quo_q;
	logic [3:0]       rem_q;
	logic [3:0]       div_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       t;
	logic [3:0]       qd;
	logic [7:0]       prod;
	logic [7:0]       rem_n;

	assign abs_sum = sum[SW-1] ? $unsigned(-sum) : $unsigned(sum);
	assign t       = {rem_q, mag_q[DW-1 -: 4]};
	assign qd      = fos_digit(t, div_q);
	assign prod    = 8'(qd) * 8'(div_q);
	assign rem_n   = t - prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ND - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mag_q <= DW'(abs_sum);
			quo_q <= '0;
			rem_q <= '0;
			neg_q <= sum[SW-1];
			div_q <= ctrl.divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[DW-5:0], 4'b0};
			quo_q <= {quo_q[DW-5:0], qd};
			rem_q <= rem_n[3:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q[SAMPLE_BITS-1:0] + 1'b1) : quo_q[SAMPLE_BITS-1:0];

endmodule

// File: design/fos_seq.sv
// Frame-end sequencer: windowed sums over the frame RAMs, division, write-back, emission.
`timescale 1ns / 1ps
module fos_seq #(
	parameter int SAMPLE_BITS = fos_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  fos_pkg::plan_t                plan,
	output logic                          busy,
	output logic                          buf_re,
	output logic [fos_pkg::IDX_W-1:0]     buf_raddr,
	input  logic [3*SAMPLE_BITS-1:0]      buf_rdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_x,
	output logic signed [SAMPLE_BITS-1:0] out_y,
	output logic signed [SAMPLE_BITS-1:0] out_z,
	output logic                          frame_last
);
	import fos_pkg::*;

	localparam int SW = SAMPLE_BITS + 4;
	localparam int WW = AXES * SAMPLE_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_LAST,
		S_DIV,
		S_WR
	} state_t;

	state_t                   state_q;
	plan_t                    plan_q;
	logic [STEP_W-1:0]        step_q;
	logic [IDX_W-1:0]         addr_q;
	logic                     rd_s1;
	logic signed [SW-1:0]     acc_q [AXES];
	logic signed [SW-1:0]     acc_sum [AXES];
	logic [SAMPLE_BITS-1:0]   quo [AXES];
	logic [AXES-1:0]          lane_done;
	logic                     out_valid_q;
	logic [SAMPLE_BITS-1:0]   out_x_q;
	logic [SAMPLE_BITS-1:0]   out_y_q;
	logic [SAMPLE_BITS-1:0]   out_z_q;
	logic                     frame_last_q;

	step_t     info;
	step_t     first_info;
	step_t     next_info;
	div_ctrl_t div_ctrl;
	logic      div_done;
	logic      wr_block;
	logic      wr_go;
	logic      prev_re;
	logic      scr_re;
	logic      prev_we;
	logic      scr_we;
	logic [WW-1:0] prev_rdata;
	logic [WW-1:0] scr_rdata;
	logic [WW-1:0] rdata;
	logic [WW-1:0] wr_word;

	assign info       = fos_step(plan_q, step_q);
	assign first_info = fos_step(plan, '0);
	assign next_info  = fos_step(plan_q, STEP_W'(step_q + 1'b1));

	assign wr_block = info.emit && out_valid_q && out_stall;
	assign wr_go    = (state_q == S_WR) && !wr_block;
	assign prev_we  = wr_go && (info.dst == DST_PREV);
	assign scr_we   = wr_go && (info.dst == DST_SCR);
	assign buf_re   = (state_q == S_ACC) && (info.src == SRC_BUF);
	assign prev_re  = (state_q == S_ACC) && (info.src == SRC_PREV);
	assign scr_re   = (state_q == S_ACC) && (info.src == SRC_SCR);
	assign buf_raddr = addr_q;

	always_comb begin
		case (info.src)
			SRC_BUF:  rdata = buf_rdata;
			SRC_PREV: rdata = prev_rdata;
			SRC_SCR:  rdata = scr_rdata;
			default:  rdata = buf_rdata;
		endcase
	end

	assign div_ctrl.start   = (state_q == S_LAST);
	assign div_ctrl.divisor = info.divisor;
	assign div_done         = &lane_done;

	// reads of a step only begin after the previous step's write, so no forwarding
	fos_ram #(.WIDTH(WW), .DEPTH(FRAME_LEN)) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (info.idx),
		.wdata (wr_word),
		.re    (prev_re),
		.raddr (addr_q),
		.rdata (prev_rdata)
	);

	fos_ram #(.WIDTH(WW), .DEPTH(FRAME_LEN)) u_scr_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (info.idx),
		.wdata (wr_word),
		.re    (scr_re),
		.raddr (addr_q),
		.rdata (scr_rdata)
	);

	for (genvar l = 0; l < AXES; l++) begin : g_lane
		logic [SAMPLE_BITS-1:0] d;
		assign d = rdata[l*SAMPLE_BITS +: SAMPLE_BITS];
		assign acc_sum[l] = acc_q[l] + {{(SW-SAMPLE_BITS){d[SAMPLE_BITS-1]}}, d};
		assign wr_word[l*SAMPLE_BITS +: SAMPLE_BITS] = quo[l];

		fos_cdiv #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (div_ctrl),
			.sum      (acc_sum[l]),
			.done     (lane_done[l]),
			.quotient (quo[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			plan_q       <= PLAN_RAW;
			step_q       <= '0;
			addr_q       <= '0;
			rd_s1        <= 1'b0;
			acc_q        <= '{default: '0};
			out_valid_q  <= 1'b0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_z_q      <= '0;
			frame_last_q <= 1'b0;
		end else begin
			rd_s1 <= (state_q == S_ACC);
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						plan_q  <= plan;
						step_q  <= '0;
						addr_q  <= first_info.lo;
						acc_q   <= '{default: '0};
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (rd_s1) begin
						for (int l = 0; l < AXES; l++) begin
							acc_q[l] <= acc_sum[l];
						end
					end
					if (addr_q == info.hi) begin
						state_q <= S_LAST;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_LAST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					if (!wr_block) begin
						if (info.emit) begin
							out_valid_q  <= 1'b1;
							out_x_q      <= quo[0];
							out_y_q      <= quo[1];
							out_z_q      <= quo[2];
							frame_last_q <= info.last;
						end
						if (info.last) begin
							state_q <= S_IDLE;
						end else begin
							step_q  <= STEP_W'(step_q + 1'b1);
							addr_q  <= next_info.lo;
							acc_q   <= '{default: '0};
							state_q <= S_ACC;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_z      = out_z_q;
	assign frame_last = frame_last_q;

endmodule

// File: design/frame_overlap_smoother_top.sv
// Frame overlap smoother: frame collection, config register and frame-end sequencer.
// Samples are taken one per cycle until a frame of ten is complete; input then stalls.
// Frame-end work, per step: the window is summed from RAM one entry per cycle, then
// divided by the digit-serial divider, ND = (SAMPLE_BITS+7)/4 base-16 digits, and
// the result is written back to a frame RAM or emitted, or both.
// Reset clears control state and filter_enable; frame RAMs hold no value until written.
`timescale 1ns / 1ps
module frame_overlap_smoother_top #(
	parameter int SAMPLE_BITS = fos_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fos_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_BITS-1:0]  sample_x,
	input  logic signed [SAMPLE_BITS-1:0]  sample_y,
	input  logic signed [SAMPLE_BITS-1:0]  sample_z,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_BITS-1:0]  out_x,
	output logic signed [SAMPLE_BITS-1:0]  out_y,
	output logic signed [SAMPLE_BITS-1:0]  out_z,
	output logic                           frame_last
);
	import fos_pkg::*;

	localparam int WW = AXES * SAMPLE_BITS;

	logic             filter_en_q;
	logic             awaiting_q;
	logic [IDX_W-1:0] fill_q;
	logic             accept;
	logic             frame_end;
	logic             seq_busy;
	plan_t            plan;
	logic             buf_re;
	logic [IDX_W-1:0] buf_raddr;
	logic [WW-1:0]    buf_rdata;

	assign pready   = 1'b1;
	assign prdata   = (paddr == REG_FILTER_EN) ? 32'(filter_en_q) : '0;
	assign in_stall = seq_busy;
	assign accept   = in_valid && !in_stall;
	assign frame_end = accept && (fill_q == IDX_W'(FRAME_LEN - 1));

	always_comb begin
		if (!filter_en_q) begin
			plan = PLAN_RAW;
		end else if (awaiting_q) begin
			plan = PLAN_COPY;
		end else begin
			plan = PLAN_MERGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_en_q <= 1'b0;
			awaiting_q  <= 1'b1;
			fill_q      <= '0;
		end else begin
			if (psel && penable && pwrite && pready && (paddr == REG_FILTER_EN)) begin
				filter_en_q <= pwdata[0];
			end
			if (accept) begin
				fill_q <= frame_end ? '0 : fill_q + 1'b1;
			end
			if (frame_end && filter_en_q) begin
				awaiting_q <= 1'b0;
			end
		end
	end

	fos_ram #(.WIDTH(WW), .DEPTH(FRAME_LEN)) u_buf_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (fill_q),
		.wdata ({sample_z, sample_y, sample_x}),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	fos_seq #(.SAMPLE_BITS(SAMPLE_BITS)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (frame_end),
		.plan       (plan),
		.busy       (seq_busy),
		.buf_re     (buf_re),
		.buf_raddr  (buf_raddr),
		.buf_rdata  (buf_rdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.frame_last (frame_last)
	);

endmodule

// File: design/fos_checker.sv
// Port-level checker for the frame overlap smoother, bound to the top level.
`timescale 1ns / 1ps
`include "frame_overlap_smoother_top_assert.svh"
module fos_checker #(
	parameter int SAMPLE_BITS = fos_pkg::SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] out_x,
	input logic signed [SAMPLE_BITS-1:0] out_y,
	input logic signed [SAMPLE_BITS-1:0] out_z,
	input logic                          frame_last
);

	// a stalled result holds until its transfer
	`FOS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(frame_last), "stalled result changed")

	// frame-end work only begins on an input transfer
	`FOS_ASSERT_SAME(a_stall_after_transfer, $rose(in_stall), $past(in_valid && !in_stall), "input stall rose without a transfer")

	// results are produced only during frame-end work
	`FOS_ASSERT_SAME(a_emit_while_busy, $rose(out_valid), $past(in_stall), "result appeared outside frame-end work")

endmodule

bind frame_overlap_smoother_top fos_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fos_checker (.*);
